// ----- hw/rtl/btex_pkg.sv -----
package btex_pkg;

    // block configuration
    localparam int MAX_SIDE        = 256;
    localparam int TEXEL_DEPTH     = 65536;
    localparam int COORD_FRAC_BITS = 16;
    localparam int WEIGHT_BITS     = 8;

    // fixed field widths
    localparam int COORD_W    = 24;
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_W     = 8;
    localparam int TEXEL_W    = 4 * CHAN_W;
    localparam int WADDR_W    = 16;

    // derived widths
    localparam int SIZE_W     = $clog2(MAX_SIDE + 1);
    localparam int X_W        = $clog2(MAX_SIDE);
    localparam int ADDR_W     = $clog2(TEXEL_DEPTH);
    localparam int CI_W       = COORD_W - COORD_FRAC_BITS;
    localparam int CF_PROD_W  = COORD_FRAC_BITS + SIZE_W;
    localparam int CI_PROD_W  = CI_W + SIZE_W + 1;
    localparam int Q_W        = CF_PROD_W + 2;
    localparam int IP_W       = CI_PROD_W + 2;
    localparam int ROW_W      = X_W + SIZE_W;
    localparam int SUM_W      = ROW_W + 1;
    localparam int CMP_W      = (SIZE_W > CFG_SIZE_W) ? SIZE_W : CFG_SIZE_W;
    localparam int LERP_W     = CHAN_W + WEIGHT_BITS + 3;

    localparam logic signed [Q_W-1:0]    Q_HALF    = Q_W'(1) << (COORD_FRAC_BITS - 1);
    localparam logic signed [LERP_W-1:0] LERP_HALF = LERP_W'(1) << (WEIGHT_BITS - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE    = 2'd2;

    // item kinds
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIT,
        ST_ROW,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_LERPX,
        ST_LERPY,
        ST_DONE
    } state_t;

    // neighbour pair and weight along one axis
    typedef struct packed {
        logic [X_W-1:0]         c0;
        logic [X_W-1:0]         c1;
        logic [WEIGHT_BITS-1:0] w;
    } axis_t;

    // width or height as used: zero acts as one, large values saturate
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] s);
        logic [CMP_W-1:0] ext;
        logic [CMP_W-1:0] res;
        ext = CMP_W'(s);
        if (ext == '0) begin
            res = CMP_W'(1);
        end else if (ext > CMP_W'(MAX_SIDE)) begin
            res = CMP_W'(MAX_SIDE);
        end else begin
            res = ext;
        end
        return SIZE_W'(res);
    endfunction

    // integer part is ci*size + k, with k = floor((cf*size - half) / one) in -1..size-1,
    // so wrapping only needs k
    function automatic axis_t fit_axis(input logic [CF_PROD_W-1:0]        cf_prod,
                                       input logic signed [CI_PROD_W-1:0] ci_prod,
                                       input logic [SIZE_W-1:0]           size,
                                       input logic                        wrap);
        logic signed [Q_W-1:0]  q;
        logic signed [Q_W-1:0]  k;
        logic signed [Q_W-1:0]  k1;
        logic signed [Q_W-1:0]  size_q;
        logic signed [IP_W-1:0] ip;
        logic signed [IP_W-1:0] ip1;
        logic signed [IP_W-1:0] size_ip;
        logic [SIZE_W-1:0]      last;
        logic [COORD_FRAC_BITS+WEIGHT_BITS-1:0] wext;
        axis_t r;
        q       = $signed(Q_W'(cf_prod)) - Q_HALF;
        k       = q >>> COORD_FRAC_BITS;
        k1      = k + Q_W'(1);
        size_q  = $signed(Q_W'(size));
        ip      = IP_W'(ci_prod) + IP_W'(k);
        ip1     = ip + IP_W'(1);
        size_ip = $signed(IP_W'(size));
        last    = size - SIZE_W'(1);
        wext    = {q[COORD_FRAC_BITS-1:0], {WEIGHT_BITS{1'b0}}} >> COORD_FRAC_BITS;
        r.w     = wext[WEIGHT_BITS-1:0];
        if (wrap) begin
            r.c0 = (k < 0) ? last[X_W-1:0] : k[X_W-1:0];
            r.c1 = (k1 == size_q) ? '0 : k1[X_W-1:0];
        end else begin
            if (ip < 0) begin
                r.c0 = '0;
            end else if (ip >= size_ip) begin
                r.c0 = last[X_W-1:0];
            end else begin
                r.c0 = ip[X_W-1:0];
            end
            if (ip1 < 0) begin
                r.c1 = '0;
            end else if (ip1 >= size_ip) begin
                r.c1 = last[X_W-1:0];
            end else begin
                r.c1 = ip1[X_W-1:0];
            end
        end
        return r;
    endfunction

    // one linear blend step, round half up, limited to the channel range
    function automatic logic [CHAN_W-1:0] lerp_ch(input logic [CHAN_W-1:0]      a,
                                                  input logic [CHAN_W-1:0]      b,
                                                  input logic [WEIGHT_BITS-1:0] w);
        logic signed [CHAN_W+1:0]      diff;
        logic signed [WEIGHT_BITS+1:0] ws;
        logic signed [LERP_W-1:0]      num;
        logic signed [LERP_W-1:0]      sh;
        logic [CHAN_W-1:0]             res;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        ws   = $signed({2'b00, w});
        num  = $signed(LERP_W'({a, {WEIGHT_BITS{1'b0}}}))
             + LERP_W'(diff) * LERP_W'(ws) + LERP_HALF;
        sh   = num >>> WEIGHT_BITS;
        if (num < 0) begin
            res = '0;
        end else if (sh > $signed(LERP_W'(255))) begin
            res = '1;
        end else begin
            res = sh[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/btex_ram.sv -----
module btex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hw/rtl/bilinear_texture_sampler.sv -----
// Bilinear texture sampler over an RGBA8 texel store.
// Input stream: s_tuser selects the item kind. A write item stores one texel
// at a linear address (row*width+column) and gives no result. A sample item
// carries signed u,v with 16 fraction bits and returns one filtered RGBA8
// texel on the m_ stream. A sample holds off the next item until it has left
// its last stage; its pace is set by the single texel memory port: the four
// neighbour texels are read one per cycle, behind coordinate multiply, fit
// and row-base stages, and followed by the two blend stages.
// The result waits in an output register, so the next item is accepted while
// the receiver stalls; a following sample then holds in its last stage until
// the output register is free. Texel memory content is undefined until written.
// Configuration (width, height, wrap mode) is written on the cfg_ port; the user
// must write it only while no sample is in flight, the block does not enforce it.
// Reset clears the control state and sets width and height to 256 and clamp mode.
module bilinear_texture_sampler
    import btex_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // texel_address, red_in, green_in, blue_in, alpha_in, coord_u, coord_v
    input  logic [95:0]           s_tdata,
    // op
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // red_out, green_out, blue_out, alpha_out
    output logic [31:0]           m_tdata
);

    state_t state_reg, state_next;

    logic [CFG_SIZE_W-1:0] image_width_reg;
    logic [CFG_SIZE_W-1:0] image_height_reg;
    logic                  wrap_mode_reg;
    logic [SIZE_W-1:0]     wd;
    logic [SIZE_W-1:0]     ht;

    logic [COORD_W-1:0]          cu_reg, cv_reg;
    logic [CF_PROD_W-1:0]        cfu_reg, cfv_reg;
    logic signed [CI_PROD_W-1:0] ciu_reg, civ_reg;
    axis_t                       ax_u, ax_v;
    axis_t                       ax_u_reg, ax_v_reg;
    logic [ROW_W-1:0]            row0_reg, row1_reg;
    logic [TEXEL_W-1:0]          t00_reg, t10_reg, t01_reg;
    logic [TEXEL_W-1:0]          top_reg, bot_reg;
    logic [TEXEL_W-1:0]          res_reg;
    logic                        m_tvalid_reg;
    logic [TEXEL_W-1:0]          m_tdata_reg;

    logic                        in_xfer;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_addr;
    logic [TEXEL_W-1:0]          ram_rdata;
    logic [ROW_W-1:0]            rd_row;
    logic [X_W-1:0]              rd_col;
    logic [SUM_W-1:0]            rd_sum;
    logic                        out_free;

    // input fields
    logic [WADDR_W-1:0] s_addr;
    logic [TEXEL_W-1:0] s_texel;
    logic [COORD_W-1:0] s_cu, s_cv;

    assign s_addr  = s_tdata[15:0];
    assign s_texel = s_tdata[47:16];
    assign s_cu    = s_tdata[71:48];
    assign s_cv    = s_tdata[95:72];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign wd = eff_size(image_width_reg);
    assign ht = eff_size(image_height_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= CFG_SIZE_W'(256);
            image_height_reg <= CFG_SIZE_W'(256);
            wrap_mode_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[CFG_SIZE_W-1:0];
                CFG_WRAP_MODE:    wrap_mode_reg    <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and memory port selection
    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        rd_row     = row0_reg;
        rd_col     = ax_u_reg.c0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == OP_SAMPLE) begin
                        state_next = ST_MUL;
                    end else begin
                        ram_we = (32'(s_addr) < 32'(TEXEL_DEPTH));
                    end
                end
            end
            ST_MUL:   state_next = ST_FIT;
            ST_FIT:   state_next = ST_ROW;
            ST_ROW:   state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1: begin
                rd_col     = ax_u_reg.c1;
                state_next = ST_RD2;
            end
            ST_RD2: begin
                rd_row     = row1_reg;
                state_next = ST_RD3;
            end
            ST_RD3: begin
                rd_row     = row1_reg;
                rd_col     = ax_u_reg.c1;
                state_next = ST_LERPX;
            end
            ST_LERPX: state_next = ST_LERPY;
            ST_LERPY: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign rd_sum   = SUM_W'(rd_row) + SUM_W'(rd_col);
    assign ram_addr = (state_reg == ST_IDLE) ? ADDR_W'(s_addr) : ADDR_W'(rd_sum);

    btex_ram #(
        .WIDTH(TEXEL_W),
        .DEPTH(TEXEL_DEPTH)
    ) u_texel_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(s_texel),
        .rdata(ram_rdata)
    );

    // neighbour coordinates and weights
    assign ax_u = fit_axis(cfu_reg, ciu_reg, wd, wrap_mode_reg);
    assign ax_v = fit_axis(cfv_reg, civ_reg, ht, wrap_mode_reg);

    // sample datapath
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cu_reg <= s_cu;
            cv_reg <= s_cv;
        end
        // scale integer and fraction parts by the image size
        if (state_reg == ST_MUL) begin
            cfu_reg <= CF_PROD_W'(cu_reg[COORD_FRAC_BITS-1:0]) * CF_PROD_W'(wd);
            cfv_reg <= CF_PROD_W'(cv_reg[COORD_FRAC_BITS-1:0]) * CF_PROD_W'(ht);
            ciu_reg <= CI_PROD_W'($signed(cu_reg[COORD_W-1:COORD_FRAC_BITS]))
                     * CI_PROD_W'($signed({1'b0, wd}));
            civ_reg <= CI_PROD_W'($signed(cv_reg[COORD_W-1:COORD_FRAC_BITS]))
                     * CI_PROD_W'($signed({1'b0, ht}));
        end
        if (state_reg == ST_FIT) begin
            ax_u_reg <= ax_u;
            ax_v_reg <= ax_v;
        end
        // row base addresses
        if (state_reg == ST_ROW) begin
            row0_reg <= ROW_W'(ax_v_reg.c0) * ROW_W'(wd);
            row1_reg <= ROW_W'(ax_v_reg.c1) * ROW_W'(wd);
        end
        // collect texels as they come out of the memory
        if (state_reg == ST_RD1) begin
            t00_reg <= ram_rdata;
        end
        if (state_reg == ST_RD2) begin
            t10_reg <= ram_rdata;
        end
        if (state_reg == ST_RD3) begin
            t01_reg <= ram_rdata;
        end
        // horizontal blend, last texel straight from the memory
        if (state_reg == ST_LERPX) begin
            for (int ch = 0; ch < 4; ch++) begin
                top_reg[ch*CHAN_W +: CHAN_W] <= lerp_ch(t00_reg[ch*CHAN_W +: CHAN_W],
                                                        t10_reg[ch*CHAN_W +: CHAN_W],
                                                        ax_u_reg.w);
                bot_reg[ch*CHAN_W +: CHAN_W] <= lerp_ch(t01_reg[ch*CHAN_W +: CHAN_W],
                                                        ram_rdata[ch*CHAN_W +: CHAN_W],
                                                        ax_u_reg.w);
            end
        end
        // vertical blend
        if (state_reg == ST_LERPY) begin
            for (int ch = 0; ch < 4; ch++) begin
                res_reg[ch*CHAN_W +: CHAN_W] <= lerp_ch(top_reg[ch*CHAN_W +: CHAN_W],
                                                        bot_reg[ch*CHAN_W +: CHAN_W],
                                                        ax_v_reg.w);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a sample transfer starts the datapath
    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == OP_SAMPLE) |=> (state_reg == ST_MUL))
        else $error("sample transfer did not start the datapath");

    // a write transfer never produces a result
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_tuser == OP_WRITE && !m_tvalid_reg) |=> !m_tvalid_reg)
        else $error("write transfer produced a result");

    // a new result only comes from the last stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the last stage");

    // no texel write while reads of a sample are in flight
    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD0 || state_reg == ST_RD1 || state_reg == ST_RD2
         || state_reg == ST_RD3 || state_reg == ST_LERPX) |-> !ram_we)
        else $error("texel write during neighbour reads");

    // a result waiting on a stall is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("pending result overwritten");

endmodule
